// File: src/binomial_inverse_transform_sampler_macros.svh
// ----------------------------------------------------------------------------
// Binomial sampler assertion macros
// Shared property wrappers for the sampler checker; clocked on clk,
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BINOMIAL_INVERSE_TRANSFORM_SAMPLER_MACROS_SVH
`define BINOMIAL_INVERSE_TRANSFORM_SAMPLER_MACROS_SVH

// same-cycle implication
`define BITS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BITS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/bits_pkg.sv
// ----------------------------------------------------------------------------
// Binomial sampler package
// Widths, fixed-point constants and the microcode control word layout.
// ----------------------------------------------------------------------------
`default_nettype none

package bits_pkg;

    localparam int MAX_STEPS  = 110;
    localparam int TRIAL_BITS = 16;

    localparam int WORD_W    = 32;
    localparam int VAR_W     = 16;
    localparam int NUM_W     = 16;
    localparam int FRAC      = 62;
    localparam int FX_W      = FRAC + 1;
    localparam int U_W       = FRAC;
    localparam int CFG_IDX_W = 2;

    localparam logic [FX_W-1:0] FX_ONE = {1'b1, {FRAC{1'b0}}};

    localparam int X_W        = $clog2(MAX_STEPS + 2);
    localparam int MUL_W      = 32;
    localparam int T_W        = 2 * MUL_W;
    localparam int ACC_W      = 4 * MUL_W;
    localparam int DIV_BITS   = 8;
    localparam int DIVIDEND_W = ((FX_W + TRIAL_BITS + DIV_BITS - 1) / DIV_BITS) * DIV_BITS;
    localparam int DIV_STEPS  = DIVIDEND_W / DIV_BITS;
    localparam int DCNT_W     = $clog2(DIV_STEPS);
    localparam int PC_W       = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_TRIALS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Q_POW_N    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_P_OVER_Q   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIRROR     = 2'd3;

    typedef enum logic [2:0] {
        MS_F_LO,
        MS_F_HI,
        MS_T0R0,
        MS_T0R1,
        MS_T1R0,
        MS_T1R1
    } mul_sel_t;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_CLEAR,
        ACC_ADD0,
        ACC_ADD32,
        ACC_ADD64,
        ACC_DIV
    } acc_op_t;

    typedef enum logic [2:0] {
        RG_HOLD,
        RG_LOAD,
        RG_SUB,
        RG_STEP,
        RG_FUPD
    } reg_op_t;

    typedef enum logic [2:0] {
        BR_NEXT,
        BR_ALWAYS,
        BR_NO_INPUT,
        BR_STOP,
        BR_DIV_BUSY,
        BR_OUT_BUSY
    } br_t;

    typedef struct packed {
        logic              in_ready;
        logic              emit;
        logic              div_set;
        reg_op_t           rop;
        mul_sel_t          mul;
        acc_op_t           aop;
        br_t               br;
        logic [PC_W-1:0]   target;
    } ctrl_t;

    typedef struct packed {
        logic stop;
        logic div_busy;
        logic abandon;
    } dp_status_t;

    typedef struct packed {
        logic in_valid;
        logic stop;
        logic div_busy;
        logic out_busy;
    } seq_cond_t;

endpackage

`default_nettype wire

// File: src/binomial_inverse_transform_sampler.sv
// ----------------------------------------------------------------------------
// Binomial inverse transform sampler
// Turns one uniform word into a binomial variate by sequential inversion.
// ----------------------------------------------------------------------------
// Each accepted word is worked on alone. A try that passes the step bound
// ends and gives no word. One inversion step is a microcode loop around a
// single 32x32 multiplier (six products) and the divider that resolves eight
// quotient bits a cycle over the 80-bit product f*(n-x). The result register
// lets the next word in while a sample still waits on m_tready. Write
// configuration only while the block is idle; cfg_ready is always high.
`default_nettype none

module binomial_inverse_transform_sampler
    import bits_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [WORD_W-1:0]    s_tdata,    // [31:0] uniform_word
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [VAR_W-1:0]          m_tdata,    // [15:0] variate
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [FX_W-1:0]      cfg_data
);

    logic [NUM_W-1:0] num_trials_reg;
    logic [FX_W-1:0]  q_pow_n_reg;
    logic [FX_W-1:0]  p_over_q_reg;
    logic             mirror_reg;
    logic             out_valid_reg, out_valid_next;
    logic [VAR_W-1:0] out_data_reg;

    ctrl_t            cw;
    dp_status_t       status;
    seq_cond_t        cond;
    logic             in_fire;
    logic             emit_fire;
    logic [VAR_W-1:0] variate;

    assign cfg_ready = 1'b1;
    assign s_tready  = cw.in_ready;
    assign in_fire   = cw.in_ready && s_tvalid;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    assign emit_fire = cw.emit && !status.abandon && (!out_valid_reg || m_tready);

    assign cond.in_valid = s_tvalid;
    assign cond.stop     = status.stop;
    assign cond.div_busy = status.div_busy;
    assign cond.out_busy = !status.abandon && out_valid_reg && !m_tready;

    bits_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .cond  (cond),
        .cw    (cw)
    );

    bits_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cw           (cw),
        .in_fire      (in_fire),
        .uniform_word (s_tdata),
        .num_trials   (num_trials_reg),
        .q_pow_n      (q_pow_n_reg),
        .p_over_q     (p_over_q_reg),
        .mirror       (mirror_reg),
        .status       (status),
        .variate      (variate)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_trials_reg <= '0;
            q_pow_n_reg    <= FX_ONE;
            p_over_q_reg   <= '0;
            mirror_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_NUM_TRIALS: num_trials_reg <= cfg_data[NUM_W-1:0];
                    CFG_Q_POW_N:    q_pow_n_reg    <= cfg_data;
                    CFG_P_OVER_Q:   p_over_q_reg   <= cfg_data;
                    CFG_MIRROR:     mirror_reg     <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            out_data_reg <= variate;
        end
    end

endmodule

`default_nettype wire

// File: src/bits_seq.sv
// ----------------------------------------------------------------------------
// Binomial sampler sequencer
// Step counter and microcode ROM; one control word per step, two-way branch.
// ----------------------------------------------------------------------------
`default_nettype none

module bits_seq
    import bits_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire seq_cond_t cond,
    output ctrl_t          cw
);

    localparam logic [PC_W-1:0] PC_IDLE = 4'd0;
    localparam logic [PC_W-1:0] PC_CMP  = 4'd1;
    localparam logic [PC_W-1:0] PC_MLO  = 4'd2;
    localparam logic [PC_W-1:0] PC_MHI  = 4'd3;
    localparam logic [PC_W-1:0] PC_DSET = 4'd4;
    localparam logic [PC_W-1:0] PC_DIV  = 4'd5;
    localparam logic [PC_W-1:0] PC_SAT  = 4'd6;
    localparam logic [PC_W-1:0] PC_P0   = 4'd7;
    localparam logic [PC_W-1:0] PC_P1   = 4'd8;
    localparam logic [PC_W-1:0] PC_P2   = 4'd9;
    localparam logic [PC_W-1:0] PC_P3   = 4'd10;
    localparam logic [PC_W-1:0] PC_P4   = 4'd11;
    localparam logic [PC_W-1:0] PC_FUPD = 4'd12;
    localparam logic [PC_W-1:0] PC_DONE = 4'd13;
    localparam logic [PC_W-1:0] PC_RET  = 4'd14;

    function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
        ctrl_t w;
        w = '{in_ready: 1'b0, emit: 1'b0, div_set: 1'b0, rop: RG_HOLD, mul: MS_F_LO,
              aop: ACC_HOLD, br: BR_NEXT, target: PC_IDLE};
        case (pc)
            PC_IDLE:
            begin
                w.in_ready = 1'b1;
                w.rop      = RG_LOAD;
                w.br       = BR_NO_INPUT;
                w.target   = PC_IDLE;
            end
            PC_CMP:
            begin
                w.rop    = RG_SUB;
                w.aop    = ACC_CLEAR;
                w.br     = BR_STOP;
                w.target = PC_DONE;
            end
            PC_MLO:
            begin
                w.mul = MS_F_LO;
            end
            PC_MHI:
            begin
                w.mul = MS_F_HI;
                w.aop = ACC_ADD0;
            end
            PC_DSET:
            begin
                w.aop     = ACC_ADD32;
                w.div_set = 1'b1;
            end
            PC_DIV:
            begin
                w.aop    = ACC_DIV;
                w.br     = BR_DIV_BUSY;
                w.target = PC_DIV;
            end
            PC_SAT:
            begin
                w.rop = RG_STEP;
                w.aop = ACC_CLEAR;
            end
            PC_P0:
            begin
                w.mul = MS_T0R0;
            end
            PC_P1:
            begin
                w.mul = MS_T0R1;
                w.aop = ACC_ADD0;
            end
            PC_P2:
            begin
                w.mul = MS_T1R0;
                w.aop = ACC_ADD32;
            end
            PC_P3:
            begin
                w.mul = MS_T1R1;
                w.aop = ACC_ADD32;
            end
            PC_P4:
            begin
                w.aop = ACC_ADD64;
            end
            PC_FUPD:
            begin
                w.rop    = RG_FUPD;
                w.br     = BR_ALWAYS;
                w.target = PC_CMP;
            end
            PC_DONE:
            begin
                w.emit   = 1'b1;
                w.br     = BR_OUT_BUSY;
                w.target = PC_DONE;
            end
            default:
            begin
                w.br     = BR_ALWAYS;
                w.target = PC_IDLE;
            end
        endcase
        return w;
    endfunction

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            taken;

    assign cw = ucode(pc_reg);

    always_comb
    begin
        case (cw.br)
            BR_ALWAYS:   taken = 1'b1;
            BR_NO_INPUT: taken = !cond.in_valid;
            BR_STOP:     taken = cond.stop;
            BR_DIV_BUSY: taken = cond.div_busy;
            BR_OUT_BUSY: taken = cond.out_busy;
            default:     taken = 1'b0;
        endcase
        pc_next = taken ? cw.target : pc_reg + PC_W'(1);
    end

    // reset lands on the return step so the input is not ready during reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_RET;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

// File: src/bits_dp.sv
// ----------------------------------------------------------------------------
// Binomial sampler datapath
// Residual u, probability f, counters, 32x32 multiplier, accumulator and
// radix-256 restoring divider, all steered by the control word.
// ----------------------------------------------------------------------------
`default_nettype none

module bits_dp
    import bits_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ctrl_t             cw,
    input  wire logic              in_fire,
    input  wire logic [WORD_W-1:0] uniform_word,
    input  wire logic [NUM_W-1:0]  num_trials,
    input  wire logic [FX_W-1:0]   q_pow_n,
    input  wire logic [FX_W-1:0]   p_over_q,
    input  wire logic              mirror,
    output dp_status_t             status,
    output logic [VAR_W-1:0]       variate
);

    logic [U_W-1:0]        u_reg, u_next;
    logic [FX_W-1:0]       f_reg, f_next;
    logic [X_W-1:0]        x_reg, x_next;
    logic [TRIAL_BITS-1:0] nx_reg, nx_next;
    logic [T_W-1:0]        t_reg, t_next;
    logic [ACC_W-1:0]      acc_reg, acc_next;
    logic [X_W-1:0]        rem_reg, rem_next;
    logic [DCNT_W-1:0]     dcnt_reg, dcnt_next;
    logic [T_W-1:0]        prod_reg;

    logic [MUL_W-1:0]      mul_a, mul_b;
    logic [T_W-1:0]        diff;
    logic                  greater;
    logic                  abandon;
    logic [X_W-1:0]        divisor;
    logic [X_W-1:0]        div_rem;
    logic [DIVIDEND_W-1:0] div_q;
    logic [X_W:0]          trial;

    assign diff    = {2'b00, u_reg} - {1'b0, f_reg};
    assign greater = !diff[T_W-1] && (diff[T_W-2:0] != '0);
    assign abandon = x_reg > X_W'(MAX_STEPS);
    assign divisor = x_reg + X_W'(1);

    assign status.stop     = abandon || !greater;
    assign status.div_busy = dcnt_reg != '0;
    assign status.abandon  = abandon;

    assign variate = mirror ? VAR_W'(nx_reg) : VAR_W'(x_reg);

    always_comb
    begin
        case (cw.mul)
            MS_F_LO:
            begin
                mul_a = f_reg[MUL_W-1:0];
                mul_b = MUL_W'(nx_reg);
            end
            MS_F_HI:
            begin
                mul_a = MUL_W'(f_reg[FX_W-1:MUL_W]);
                mul_b = MUL_W'(nx_reg);
            end
            MS_T0R0:
            begin
                mul_a = t_reg[MUL_W-1:0];
                mul_b = p_over_q[MUL_W-1:0];
            end
            MS_T0R1:
            begin
                mul_a = t_reg[MUL_W-1:0];
                mul_b = MUL_W'(p_over_q[FX_W-1:MUL_W]);
            end
            MS_T1R0:
            begin
                mul_a = t_reg[T_W-1:MUL_W];
                mul_b = p_over_q[MUL_W-1:0];
            end
            MS_T1R1:
            begin
                mul_a = t_reg[T_W-1:MUL_W];
                mul_b = MUL_W'(p_over_q[FX_W-1:MUL_W]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // eight quotient bits per cycle, dividend shifts out the top of the accumulator's low 80 bits
    always_comb
    begin
        div_rem = rem_reg;
        div_q   = acc_reg[DIVIDEND_W-1:0];
        trial   = '0;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            trial = {div_rem, div_q[DIVIDEND_W-1]};
            div_q = {div_q[DIVIDEND_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor})
            begin
                div_rem  = X_W'(trial - {1'b0, divisor});
                div_q[0] = 1'b1;
            end
            else
            begin
                div_rem = trial[X_W-1:0];
            end
        end
    end

    always_comb
    begin
        u_next    = u_reg;
        f_next    = f_reg;
        x_next    = x_reg;
        nx_next   = nx_reg;
        t_next    = t_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        dcnt_next = dcnt_reg;

        case (cw.rop)
            RG_LOAD:
            begin
                if (in_fire)
                begin
                    u_next  = {uniform_word, {(U_W-WORD_W){1'b0}}};
                    f_next  = (q_pow_n > FX_ONE) ? FX_ONE : q_pow_n;
                    x_next  = '0;
                    nx_next = TRIAL_BITS'(num_trials);
                end
            end
            RG_SUB:
            begin
                u_next = diff[U_W-1:0];
            end
            RG_STEP:
            begin
                t_next = (acc_reg[DIVIDEND_W-1:T_W] != '0) ? '1 : acc_reg[T_W-1:0];
                x_next = x_reg + X_W'(1);
                if (nx_reg != '0)
                begin
                    nx_next = nx_reg - TRIAL_BITS'(1);
                end
            end
            RG_FUPD:
            begin
                f_next = (acc_reg[ACC_W-1:2*FRAC] != '0) ? FX_ONE
                                                          : {1'b0, acc_reg[2*FRAC-1:FRAC]};
            end
            default:
            begin
            end
        endcase

        case (cw.aop)
            ACC_CLEAR: acc_next = '0;
            ACC_ADD0:  acc_next = acc_reg + ACC_W'(prod_reg);
            ACC_ADD32: acc_next = acc_reg + (ACC_W'(prod_reg) << MUL_W);
            ACC_ADD64: acc_next = acc_reg + (ACC_W'(prod_reg) << (2 * MUL_W));
            ACC_DIV:
            begin
                acc_next[DIVIDEND_W-1:0] = div_q;
                rem_next                 = div_rem;
                if (dcnt_reg != '0)
                begin
                    dcnt_next = dcnt_reg - DCNT_W'(1);
                end
            end
            default:
            begin
            end
        endcase

        if (cw.div_set)
        begin
            dcnt_next = DCNT_W'(DIV_STEPS - 1);
            rem_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg <= '0;
        end
        else
        begin
            dcnt_reg <= dcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg    <= u_next;
        f_reg    <= f_next;
        x_reg    <= x_next;
        nx_reg   <= nx_next;
        t_reg    <= t_next;
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        prod_reg <= mul_a * mul_b;
    end

endmodule

`default_nettype wire

// File: src/bits_chk.sv
// ----------------------------------------------------------------------------
// Binomial sampler port checker
// Stream-side properties of the sampler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "binomial_inverse_transform_sampler_macros.svh"

module bits_chk
    import bits_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             s_tvalid,
    input wire logic             s_tready,
    input wire logic             m_tvalid,
    input wire logic             m_tready,
    input wire logic [VAR_W-1:0] m_tdata
);

    `BITS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result word dropped")
    `BITS_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata), "stalled word changed")
    `BITS_ASSERT_NEXT(a_one_word, s_tvalid && s_tready, !s_tready, "second word taken while busy")
    `BITS_ASSERT_NOW(a_no_bypass, $rose(m_tvalid), !$past(s_tvalid && s_tready), "result without work")

endmodule

bind binomial_inverse_transform_sampler bits_chk u_bits_chk (.*);

`default_nettype wire

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// Binomial inverse transform sampler testbench
// Streams uniform words into the sampler across several parameter settings,
// predicts each variate (or the abandoned try) in a local fixed-point model of
// the inversion loop and compares every output word in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    import bits_pkg::*;

    localparam int     PERIOD       = 12;
    localparam int     SETTLE       = 21 * (MAX_STEPS + 1) + 64;
    localparam int     PRESS_CYCLES = 600;
    localparam longint LIMIT_CYCLES = 20_000_000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [WORD_W-1:0]    s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [VAR_W-1:0]     m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_NUM_TRIALS;
    logic [FX_W-1:0]      cfg_data  = '0;

    // shadow of the sampler registers
    logic [NUM_W-1:0]     set_trials = '0;
    logic [FX_W-1:0]      set_qn     = FX_ONE;
    logic [FX_W-1:0]      set_ratio  = '0;
    logic                 set_mirror = 1'b0;

    logic [WORD_W-1:0]    uniform_fifo[$];
    logic [VAR_W-1:0]     pending_variates[$];
    logic [VAR_W-1:0]     predicted;
    logic [VAR_W-1:0]     want;

    int                   words_queued  = 0;
    int                   words_taken   = 0;
    int                   errors        = 0;
    int                   send_idle_pct = 20;
    int                   recv_idle_pct = 20;
    int                   send_gap      = 0;
    int                   recv_gap      = 0;
    logic                 rx_hold       = 1'b0;
    logic                 press_go      = 1'b0;

    binomial_inverse_transform_sampler DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #(PERIOD / 2) clk = 1'b1;
        #(PERIOD / 2) clk = 1'b0;
    end

    // sequential inversion; returns 0 when the try passes the step bound
    function automatic bit invert_uniform(input logic [WORD_W-1:0] word,
                                          output logic [VAR_W-1:0] variate);
        logic [127:0]     prod;
        logic [63:0]      t;
        logic [63:0]      u;
        logic [63:0]      f;
        logic [NUM_W-1:0] left;
        int unsigned      x;
        u = {32'b0, word} << 30;
        f = (set_qn > FX_ONE) ? 64'(FX_ONE) : 64'(set_qn);
        left = set_trials;
        x = 0;
        variate = '0;
        while (u > f)
        begin
            u = u - f;
            prod = {64'b0, f} * {112'b0, left};
            prod = prod / (x + 1);
            t = (|prod[127:64]) ? '1 : prod[63:0];
            if (left != 0)
                left = left - 1'b1;
            x = x + 1;
            prod = {64'b0, t} * {65'b0, set_ratio};
            prod = prod >> FRAC;
            f = (prod > FX_ONE) ? 64'(FX_ONE) : prod[63:0];
            if (x > MAX_STEPS)
                return 1'b0;
        end
        variate = set_mirror ? left : x[VAR_W-1:0];
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            send_gap = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                words_taken++;
                if (invert_uniform(s_tdata, predicted))
                    pending_variates.push_back(predicted);
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (uniform_fifo.size() > 0 && send_idle_pct > 0
                         && $urandom_range(99) < send_idle_pct)
                begin
                    send_gap = $urandom_range(19, 1) - 1;
                    s_tvalid <= 1'b0;
                end
                else if (uniform_fifo.size() > 0)
                begin
                    s_tdata  <= uniform_fifo.pop_front();
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_gap = 0;
        end
        else if (rx_hold)
            m_tready <= 1'b0;
        else if (recv_gap > 0)
        begin
            recv_gap--;
            m_tready <= 1'b0;
        end
        else if (recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct)
        begin
            recv_gap = $urandom_range(19, 1) - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_variates.size() == 0)
            begin
                $display("%0t: variate word %0d with none expected", $time, m_tdata);
                errors++;
            end
            else
            begin
                want = pending_variates.pop_front();
                if (m_tdata !== want)
                begin
                    $display("%0t: variate mismatch, expected %0d, actual %0d",
                             $time, want, m_tdata);
                    errors++;
                end
            end
        end
    end

    // long receiver stall so the sampler backs up into its input
    initial
    begin
        wait (press_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (PRESS_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    initial
    begin
        #(LIMIT_CYCLES * PERIOD);
        $display("CHECK FAILED");
        $finish;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FX_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_NUM_TRIALS: set_trials = value[NUM_W-1:0];
            CFG_Q_POW_N:    set_qn     = value;
            CFG_P_OVER_Q:   set_ratio  = value;
            CFG_MIRROR:     set_mirror = value[0];
            default:
            begin
            end
        endcase
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [FX_W-1:0] junk_with(input logic [15:0] low);
        logic [FX_W-1:0] v;
        v = FX_W'({$urandom, $urandom});
        v[15:0] = low;
        return v;
    endfunction

    function automatic logic [FX_W-1:0] to_fixed(input real r);
        logic [FX_W-1:0] v;
        v = r * (2.0 ** FRAC);
        return v;
    endfunction

    task automatic set_binomial(input int unsigned trials, input real p);
        real  pp;
        real  qq;
        logic flip;
        flip = p > 0.5;
        pp = flip ? 1.0 - p : p;
        qq = 1.0 - pp;
        write_reg(CFG_NUM_TRIALS, junk_with(trials[15:0]));
        write_reg(CFG_Q_POW_N, to_fixed(qq ** trials));
        write_reg(CFG_P_OVER_Q, to_fixed(pp / qq));
        write_reg(CFG_MIRROR, junk_with({15'd0, flip}));
    endtask

    task automatic queue_word(input logic [WORD_W-1:0] w);
        uniform_fifo.push_back(w);
        words_queued++;
    endtask

    task automatic queue_random(input int count);
        int r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(19);
            if (r == 0)
                queue_word('0);
            else if (r == 1)
                queue_word('1);
            else
                queue_word($urandom);
        end
    endtask

    // wait for every word taken and every variate seen, then for one worst-case try
    task automatic settle_idle();
        while (words_taken != words_queued || pending_variates.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    initial
    begin
        int unsigned trials;
        real         pp;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: f starts at one
        queue_word('0);
        queue_word('1);
        queue_word(32'h0000_0001);
        settle_idle();

        // p = 1/2, n = 1: boundary at u = f and count reaching n
        set_binomial(1, 0.5);
        queue_word('0);
        queue_word(32'h7FFF_FFFF);
        queue_word(32'h8000_0000);
        queue_word(32'h8000_0001);
        queue_word('1);
        settle_idle();

        set_binomial(3, 0.75);
        queue_word('0);
        queue_word('1);
        queue_word(32'h3000_0000);
        settle_idle();

        // f drops to zero after the first step
        write_reg(CFG_NUM_TRIALS, junk_with(16'd2));
        write_reg(CFG_Q_POW_N, FX_ONE >> 2);
        write_reg(CFG_P_OVER_Q, '0);
        write_reg(CFG_MIRROR, junk_with(16'd0));
        queue_word(32'h4000_0000);
        queue_word(32'h4000_0001);
        queue_word(32'h2000_0000);
        settle_idle();

        // zero q_pow_n, largest n, mirrored
        write_reg(CFG_NUM_TRIALS, junk_with(16'hFFFF));
        write_reg(CFG_Q_POW_N, '0);
        write_reg(CFG_P_OVER_Q, FX_ONE);
        write_reg(CFG_MIRROR, junk_with(16'd1));
        queue_word('0);
        queue_word(32'h0000_0005);
        settle_idle();

        // registers above one saturate
        write_reg(CFG_NUM_TRIALS, junk_with(16'd0));
        write_reg(CFG_Q_POW_N, '1);
        write_reg(CFG_P_OVER_Q, '1);
        write_reg(CFG_MIRROR, junk_with(16'd0));
        queue_word('1);
        queue_word(32'hA5A5_A5A5);
        settle_idle();

        // f*(n-x) overflows 64 bits
        write_reg(CFG_NUM_TRIALS, junk_with(16'hFFFF));
        write_reg(CFG_Q_POW_N, FX_ONE >> 1);
        write_reg(CFG_P_OVER_Q, FX_ONE);
        queue_word(32'h8000_0001);
        queue_word('1);
        queue_word(32'h1234_5678);
        settle_idle();

        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph == 7)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                set_binomial(65535, 0.99999);
            end
            else
            begin
                send_idle_pct = 20 * $urandom_range(2);
                recv_idle_pct = 20 * $urandom_range(2);
                case ($urandom_range(3))
                    0, 1:
                        set_binomial($urandom_range(30, 1), $urandom_range(999, 1) / 1000.0);
                    2:
                    begin
                        trials = $urandom_range(65535, 100);
                        pp = real'($urandom_range(8, 1)) / real'(trials);
                        set_binomial(trials, $urandom_range(1) ? 1.0 - pp : pp);
                    end
                    default:
                        set_binomial($urandom_range(12), 0.5);
                endcase
            end
            queue_random(100);
            if (ph == 1)
                press_go = 1'b1;
            settle_idle();

            // raw register values, mostly out of any consistent setting
            if (ph == 4)
            begin
                write_reg(CFG_NUM_TRIALS, junk_with(16'($urandom)));
                write_reg(CFG_Q_POW_N, FX_W'({$urandom, $urandom}) >> $urandom_range(8));
                write_reg(CFG_P_OVER_Q, FX_W'({$urandom, $urandom}) >> $urandom_range(8));
                write_reg(CFG_MIRROR, junk_with(16'($urandom)));
                queue_random(8);
                settle_idle();
            end
        end

        if (errors == 0 && pending_variates.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// File: binomial_inverse_transform_sampler.f
+incdir+src
src/bits_pkg.sv
src/bits_seq.sv
src/bits_dp.sv
src/binomial_inverse_transform_sampler.sv
src/bits_chk.sv
tb/tb.sv
